[design/wdce_pkg.sv]
// ----------------------------------------------------------------------------
// wdce_pkg: shared types and constants of the Winternitz digit encoder
// Holds the configuration record, the job record passed from the front to
// the back, register indexes and reset values.
// ----------------------------------------------------------------------------
package wdce_pkg;

	// Digest bytes per message saturate at this count.
	localparam int MAX_HASH_BYTES = 32;

	// Register indexes on the configuration port (byte address 4*index).
	localparam logic [1:0] REG_DIGIT_WIDTH_LOG = 2'd0;
	localparam logic [1:0] REG_HASH_BYTES      = 2'd1;
	localparam logic [1:0] REG_CHECKSUM_SHIFT  = 2'd2;
	localparam logic [1:0] REG_DIGIT_COUNT     = 2'd3;

	localparam logic [1:0] RST_DIGIT_WIDTH_LOG = 2'd3;
	localparam logic [5:0] RST_HASH_BYTES      = 6'd24;
	localparam logic [3:0] RST_CHECKSUM_SHIFT  = 4'd0;
	localparam logic [8:0] RST_DIGIT_COUNT     = 9'd26;

	typedef struct packed {
		logic [1:0] digit_width_log;
		logic [5:0] hash_bytes;
		logic [3:0] checksum_shift;
		logic [8:0] digit_count;
	} cfg_t;

	// One digest byte, plus the message checksum when the byte ends a message.
	typedef struct packed {
		logic [7:0]  hash_byte;
		logic        msg_end;
		logic [15:0] checksum;
	} job_t;

endpackage

[design/wdce_front.sv]
// ----------------------------------------------------------------------------
// wdce_front: byte intake and checksum accumulation
// Takes one byte per cycle unless the queue is full, adds its digit complements
// to the running sum, finds the message end, forms the job's shifted checksum.
// ----------------------------------------------------------------------------
module wdce_front (
	input  logic             clk,
	input  logic             arst_n,
	input  wdce_pkg::cfg_t   cfg,
	input  logic             push,
	input  logic             full,
	input  logic [7:0]       hash_byte,
	output logic             job_push,
	output wdce_pkg::job_t   job
);

	localparam logic [6:0] MAX_HB = 7'(wdce_pkg::MAX_HASH_BYTES);

	logic [5:0]  byte_counter_q;
	logic [15:0] checksum_sum_q;
	logic [7:0]  nb;
	logic [7:0]  inc;
	logic [5:0]  bc_next;
	logic [6:0]  n_bytes;
	logic [15:0] sum_next;
	logic        msg_end;

	assign job_push = push && !full;
	assign nb       = ~hash_byte;

	// The largest digit minus d equals the bitwise complement of d within its w bits.
	always_comb begin
		inc = 8'd0;
		case (cfg.digit_width_log)
			2'd0: begin
				for (int i = 0; i < 8; i++) begin
					inc = inc + {7'd0, nb[i]};
				end
			end
			2'd1: inc = {6'd0, nb[7:6]} + {6'd0, nb[5:4]} + {6'd0, nb[3:2]} + {6'd0, nb[1:0]};
			2'd2: inc = {4'd0, nb[7:4]} + {4'd0, nb[3:0]};
			default: inc = nb;
		endcase
	end

	always_comb begin
		if (cfg.hash_bytes == 6'd0) begin
			n_bytes = 7'd1;
		end else if ({1'b0, cfg.hash_bytes} > MAX_HB) begin
			n_bytes = MAX_HB;
		end else begin
			n_bytes = {1'b0, cfg.hash_bytes};
		end
	end

	assign bc_next  = byte_counter_q + 6'd1;
	assign sum_next = checksum_sum_q + {8'd0, inc};
	assign msg_end  = ({1'b0, bc_next} >= n_bytes) || (bc_next == 6'd0);

	always_comb begin
		job.hash_byte = hash_byte;
		job.msg_end   = msg_end;
		job.checksum  = sum_next << cfg.checksum_shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_counter_q <= 6'd0;
			checksum_sum_q <= 16'd0;
		end else if (job_push) begin
			if (msg_end) begin
				byte_counter_q <= 6'd0;
				checksum_sum_q <= 16'd0;
			end else begin
				byte_counter_q <= bc_next;
				checksum_sum_q <= sum_next;
			end
		end
	end

endmodule

[design/wdce_fifo.sv]
// ----------------------------------------------------------------------------
// wdce_fifo: job queue between front and back
// A small first-in first-out store of jobs with a fill count.
// ----------------------------------------------------------------------------
module wdce_fifo #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  wdce_pkg::job_t   wr_data,
	input  logic             rd_en,
	output wdce_pkg::job_t   rd_data,
	output logic             full,
	output logic             not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	wdce_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[design/wdce_back.sv]
// ----------------------------------------------------------------------------
// wdce_back: digit serializer
// Cuts each job into digits, most significant first, one per cycle while the
// output register is free, counts message digits and holds the oldest result.
// ----------------------------------------------------------------------------
module wdce_back (
	input  logic             clk,
	input  logic             arst_n,
	input  wdce_pkg::cfg_t   cfg,
	input  logic             job_valid,
	input  wdce_pkg::job_t   job,
	output logic             job_take,
	input  logic             pop,
	output logic             empty,
	output logic [7:0]       digit,
	output logic [8:0]       digit_index,
	output logic             last_digit
);

	logic        busy_q;
	logic [23:0] shreg_q;
	logic [4:0]  step_q;
	logic [4:0]  nsteps_q;
	logic        msg_end_q;
	logic [8:0]  digit_counter_q;
	logic        out_valid_q;
	logic [7:0]  digit_q;
	logic [8:0]  index_q;
	logic        last_q;

	logic [7:0]  cur_digit;
	logic [23:0] shreg_next;
	logic        last_step;
	logic        emit;
	logic        flag_last;
	logic        out_free;
	logic        adv;
	logic [4:0]  per_byte;
	logic [4:0]  per_cks;

	assign empty       = !out_valid_q;
	assign digit       = digit_q;
	assign digit_index = index_q;
	assign last_digit  = last_q;

	always_comb begin
		case (cfg.digit_width_log)
			2'd0: begin
				cur_digit  = {7'd0, shreg_q[23]};
				shreg_next = shreg_q << 1;
			end
			2'd1: begin
				cur_digit  = {6'd0, shreg_q[23:22]};
				shreg_next = shreg_q << 2;
			end
			2'd2: begin
				cur_digit  = {4'd0, shreg_q[23:20]};
				shreg_next = shreg_q << 4;
			end
			default: begin
				cur_digit  = shreg_q[23:16];
				shreg_next = shreg_q << 8;
			end
		endcase
	end

	assign per_byte  = 5'd8 >> cfg.digit_width_log;
	assign per_cks   = 5'd16 >> cfg.digit_width_log;
	assign last_step = (step_q == nsteps_q - 5'd1);
	assign emit      = digit_counter_q < cfg.digit_count;
	// The end flag marks index digit_count-1 and a message's last checksum digit.
	assign flag_last = ({1'b0, digit_counter_q} + 10'd1 == {1'b0, cfg.digit_count})
		|| (msg_end_q && last_step);
	assign out_free  = !out_valid_q || pop;
	assign adv       = busy_q && (!emit || out_free);
	assign job_take  = job_valid && (!busy_q || (adv && last_step));

	always_ff @(posedge clk) begin
		if (job_take) begin
			shreg_q   <= {job.hash_byte, job.checksum};
			msg_end_q <= job.msg_end;
			nsteps_q  <= per_byte + (job.msg_end ? per_cks : 5'd0);
		end else if (adv) begin
			shreg_q <= shreg_next;
		end
		if (adv && emit) begin
			digit_q <= cur_digit;
			index_q <= digit_counter_q;
			last_q  <= flag_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q          <= 1'b0;
			step_q          <= 5'd0;
			digit_counter_q <= 9'd0;
			out_valid_q     <= 1'b0;
		end else begin
			if (job_take) begin
				busy_q <= 1'b1;
				step_q <= 5'd0;
			end else if (adv) begin
				if (last_step) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q + 5'd1;
			end
			if (adv) begin
				if (last_step && msg_end_q) begin
					digit_counter_q <= 9'd0;
				end else if (emit) begin
					digit_counter_q <= digit_counter_q + 9'd1;
				end
			end
			if (adv && emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[design/winternitz_digit_checksum_encoder_top.sv]
// ----------------------------------------------------------------------------
// winternitz_digit_checksum_encoder_top: Winternitz digit and checksum encoder
// Splits digest bytes into w-bit digits and appends the 16-bit checksum
// digits at each message end, flagging the final digit.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Payload
//  input     push / full         hash_byte[7:0]
//  result    empty / pop         digit[7:0], digit_index[8:0], last_digit
//  config    psel/penable/pwrite paddr[3:0], pwdata[31:0], prdata[31:0]
//
//  The front takes one byte per cycle while the job queue has room.
//  The back emits one digit per cycle while the output register is free: a
//  byte gives 8/w digits (at least one), and the byte that ends a message
//  gives 16/w more for the checksum. Digits beyond the digit count still take a step.
//  Reset clears counters, queue and output register; results stall in place.
// ----------------------------------------------------------------------------
module winternitz_digit_checksum_encoder_top #(
	parameter int JOB_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  hash_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  digit,
	output logic [8:0]  digit_index,
	output logic        last_digit,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	wdce_pkg::cfg_t cfg_q;
	wdce_pkg::job_t front_job;
	wdce_pkg::job_t back_job;
	logic           job_push;
	logic           job_take;
	logic           job_valid;
	logic           cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.digit_width_log <= wdce_pkg::RST_DIGIT_WIDTH_LOG;
			cfg_q.hash_bytes      <= wdce_pkg::RST_HASH_BYTES;
			cfg_q.checksum_shift  <= wdce_pkg::RST_CHECKSUM_SHIFT;
			cfg_q.digit_count     <= wdce_pkg::RST_DIGIT_COUNT;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				wdce_pkg::REG_DIGIT_WIDTH_LOG: cfg_q.digit_width_log <= pwdata[1:0];
				wdce_pkg::REG_HASH_BYTES:      cfg_q.hash_bytes      <= pwdata[5:0];
				wdce_pkg::REG_CHECKSUM_SHIFT:  cfg_q.checksum_shift  <= pwdata[3:0];
				wdce_pkg::REG_DIGIT_COUNT:     cfg_q.digit_count     <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			wdce_pkg::REG_DIGIT_WIDTH_LOG: prdata = {30'd0, cfg_q.digit_width_log};
			wdce_pkg::REG_HASH_BYTES:      prdata = {26'd0, cfg_q.hash_bytes};
			wdce_pkg::REG_CHECKSUM_SHIFT:  prdata = {28'd0, cfg_q.checksum_shift};
			wdce_pkg::REG_DIGIT_COUNT:     prdata = {23'd0, cfg_q.digit_count};
			default:                       prdata = 32'd0;
		endcase
	end

	wdce_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.full      (full),
		.hash_byte (hash_byte),
		.job_push  (job_push),
		.job       (front_job)
	);

	wdce_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (job_push),
		.wr_data   (front_job),
		.rd_en     (job_take),
		.rd_data   (back_job),
		.full      (full),
		.not_empty (job_valid)
	);

	wdce_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.job_valid   (job_valid),
		.job         (back_job),
		.job_take    (job_take),
		.pop         (pop),
		.empty       (empty),
		.digit       (digit),
		.digit_index (digit_index),
		.last_digit  (last_digit)
	);

endmodule

[design/wdce_checker.sv]
// ----------------------------------------------------------------------------
// wdce_checker: port-level checks of the encoder
// Watches the top-level ports for reset, result hold and register readback.
// ----------------------------------------------------------------------------
module wdce_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic [7:0]  hash_byte,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  digit,
	input logic [8:0]  digit_index,
	input logic        last_digit,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	// Reset leaves no result offered.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result offered during reset");

	// A result that is not taken stays in place unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(digit) && $stable(digit_index)
			&& $stable(last_digit)))
		else $error("waiting result changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	// No register is wider than nine bits.
	a_read_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && !pwrite) |-> (prdata[31:9] == 23'd0))
		else $error("register readback has bits set above its width");

endmodule

bind winternitz_digit_checksum_encoder_top wdce_port_checks u_wdce_port_checks (.*);
